// ===== rtl/g2ab_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// g2ab_pkg
// Shared types, constants and conversion tables for the gamma-2 premultiplied
// alpha blend pipeline.
// ----------------------------------------------------------------------------
package g2ab_pkg;

  localparam int          LIN_W  = 17;
  localparam int          GA_W   = 9;
  localparam int          NCHAN  = 3;
  localparam logic [16:0] FX_ONE = 17'h10000;
  localparam logic [8:0]  GA_ONE = 9'd256;

  typedef logic [LIN_W-1:0] lin_t;
  typedef lin_t lut_t [256];

  typedef struct packed {
    logic adv_hi;
    logic adv_lo;
  } stage_ctrl_t;

  // (c/255)^2 as a 1.16 fraction
  function automatic lut_t build_color_lut();
    lut_t lut;
    longint unsigned n;
    for (int c = 0; c < 256; c++) begin
      n = longint'(c) * longint'(c) * 65536 + 32512;
      lut[c] = LIN_W'(n / 65025);
    end
    return lut;
  endfunction

  // a/255 as a 1.16 fraction
  function automatic lut_t build_alpha_lut();
    lut_t lut;
    longint unsigned n;
    for (int a = 0; a < 256; a++) begin
      n = longint'(a) * 65536 + 127;
      lut[a] = LIN_W'(n / 255);
    end
    return lut;
  endfunction

  // smallest linear value whose rounded 255*sqrt reaches code b
  function automatic lut_t build_root_lut();
    lut_t lut;
    longint unsigned x;
    longint unsigned n;
    lut[0] = '0;
    for (int b = 1; b < 256; b++) begin
      x = longint'(b) * 512 - 256;
      n = x * x + 260099;
      lut[b] = LIN_W'(n / 260100);
    end
    return lut;
  endfunction

  localparam lut_t COLOR_LIN = build_color_lut();
  localparam lut_t ALPHA_LIN = build_alpha_lut();
  localparam lut_t ROOT_TH   = build_root_lut();

endpackage
`default_nettype wire

// ===== rtl/g2ab_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// g2ab_if
// Valid/ready channels for the source/destination pixel pair and the
// blended pixel.
// ----------------------------------------------------------------------------
interface g2ab_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_pixel;
  logic [31:0] dest_pixel;

  modport source (output valid, output source_pixel, output dest_pixel, input ready);
  modport sink   (input valid, input source_pixel, input dest_pixel, output ready);
endinterface

interface g2ab_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] blended_pixel;

  modport source (output valid, output blended_pixel, input ready);
  modport sink   (input valid, input blended_pixel, output ready);
endinterface
`default_nettype wire

// ===== rtl/gamma2_premultiplied_alpha_blend_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gamma2_premultiplied_alpha_blend_top
// Premultiplied over blend of one ARGB8888 source pixel onto one destination
// pixel in gamma-2 linear space, with a global source opacity.
// ----------------------------------------------------------------------------
// One pixel pair is taken per clock and one blended pixel leaves per clock
// while the output accepts it, through five register stages: table decode to
// linear, global alpha scaling, the blend multiply, and two halves of the
// binary search that encodes each color back to 8 bits. Every stage holds its
// own valid bit, so a stall at the output backs up stage by stage and empty
// stages still fill. global_alpha (value over 256, reset 256, values above 256
// act as 256) is written through cfg_we/cfg_wdata; the user must do so only
// while no transfer is in flight, which the block itself does not enforce.
module gamma2_premultiplied_alpha_blend_top (
  input  logic       clk,
  input  logic       rst_n,
  g2ab_in_if.sink    in_pix,
  g2ab_out_if.source out_pix,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata
);
  import g2ab_pkg::*;

  // configuration
  logic [GA_W-1:0] g_r;
  logic [GA_W-1:0] g_sat;

  // stage valids and advance
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  stage_ctrl_t root_ctl;

  // stage 1: linear values
  lin_t sl_r [NCHAN];
  lin_t dl_r [NCHAN];
  lin_t sa_r;
  lin_t da_r;

  // stage 2: scaled source
  lin_t t_nxt  [NCHAN];
  lin_t t_r    [NCHAN];
  lin_t d2_r   [NCHAN];
  lin_t ta_nxt;
  lin_t ta_r;
  lin_t da2_r;
  logic [25:0] tprod [NCHAN];
  logic [25:0] taprod;

  // stage 3: blend
  lin_t        r_nxt [NCHAN];
  lin_t        r_r   [NCHAN];
  lin_t        ra_nxt;
  lin_t        ra_r;
  lin_t        inv_ta;
  logic [33:0] bprod [NCHAN];
  logic [18:0] bsum  [NCHAN];
  logic [33:0] aprod;
  logic [17:0] asum;

  // stage 4/5: output alpha
  logic [24:0] acode_prod;
  logic [7:0]  a4_nxt;
  logic [7:0]  a4_r;
  logic [7:0]  a5_r;
  logic [7:0]  code [NCHAN];

  assign g_sat = (g_r > GA_ONE) ? GA_ONE : g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r <= GA_ONE;
    end else if (cfg_we) begin
      g_r <= cfg_wdata;
    end
  end

  assign rdy5 = !v5_r || out_pix.ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_pix.ready = rdy1;

  assign root_ctl.adv_hi = rdy4;
  assign root_ctl.adv_lo = rdy5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_pix.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // scale by global alpha
  always_comb begin
    for (int i = 0; i < NCHAN; i++) begin
      tprod[i] = 26'(sl_r[i]) * 26'(g_sat) + 26'd128;
      t_nxt[i] = (tprod[i][25:8] > 18'(FX_ONE)) ? FX_ONE : tprod[i][24:8];
    end
    taprod = 26'(sa_r) * 26'(g_sat) + 26'd128;
    ta_nxt = (taprod[25:8] > 18'(FX_ONE)) ? FX_ONE : taprod[24:8];
  end

  // over blend
  always_comb begin
    inv_ta = FX_ONE - ta_r;
    for (int i = 0; i < NCHAN; i++) begin
      bprod[i] = 34'(inv_ta) * 34'(d2_r[i]) + 34'd32768;
      bsum[i]  = 19'(t_r[i]) + 19'(bprod[i][33:16]);
      r_nxt[i] = (bsum[i] > 19'(FX_ONE)) ? FX_ONE : bsum[i][16:0];
    end
    aprod  = 34'(ta_r) * 34'(da2_r) + 34'd32768;
    asum   = 18'(ta_r) + 18'(da2_r) - aprod[33:16];
    ra_nxt = (asum > 18'(FX_ONE)) ? FX_ONE : asum[16:0];
  end

  // alpha back to 8 bits
  always_comb begin
    acode_prod = {ra_r, 8'd0} - 25'(ra_r) + 25'd32768;
    a4_nxt     = (acode_prod[24:16] > 9'd255) ? 8'd255 : acode_prod[23:16];
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < NCHAN; i++) begin
        sl_r[i] <= COLOR_LIN[in_pix.source_pixel[8*i +: 8]];
        dl_r[i] <= COLOR_LIN[in_pix.dest_pixel[8*i +: 8]];
      end
      sa_r <= ALPHA_LIN[in_pix.source_pixel[31:24]];
      da_r <= ALPHA_LIN[in_pix.dest_pixel[31:24]];
    end
    if (rdy2) begin
      for (int i = 0; i < NCHAN; i++) begin
        t_r[i]  <= t_nxt[i];
        d2_r[i] <= dl_r[i];
      end
      ta_r  <= ta_nxt;
      da2_r <= da_r;
    end
    if (rdy3) begin
      for (int i = 0; i < NCHAN; i++) begin
        r_r[i] <= r_nxt[i];
      end
      ra_r <= ra_nxt;
    end
    if (rdy4) begin
      a4_r <= a4_nxt;
    end
    if (rdy5) begin
      a5_r <= a4_r;
    end
  end

  for (genvar gi = 0; gi < NCHAN; gi++) begin : g_root
    g2ab_root u_root (
      .clk      (clk),
      .ctl      (root_ctl),
      .lin_in   (r_r[gi]),
      .code_out (code[gi])
    );
  end

  assign out_pix.valid         = v5_r;
  assign out_pix.blended_pixel = {a5_r, code[2], code[1], code[0]};

endmodule
`default_nettype wire

// ===== rtl/g2ab_root.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// g2ab_root
// Two-stage binary search that turns a linear 1.16 color value into its
// 8-bit gamma-2 code, round(255 * sqrt(x)).
// ----------------------------------------------------------------------------
module g2ab_root (
  input  logic                  clk,
  input  g2ab_pkg::stage_ctrl_t ctl,
  input  g2ab_pkg::lin_t        lin_in,
  output logic [7:0]            code_out
);
  import g2ab_pkg::*;

  logic [7:0] hi_nxt;
  logic [7:0] hi_r;
  logic [7:0] lo_nxt;
  logic [7:0] lo_r;
  logic [7:0] cand_hi;
  logic [7:0] cand_lo;
  lin_t       lin_r;

  // upper four code bits
  always_comb begin
    hi_nxt  = '0;
    cand_hi = '0;
    for (int i = 7; i >= 4; i--) begin
      cand_hi = hi_nxt | (8'd1 << i);
      if (lin_in >= ROOT_TH[cand_hi]) begin
        hi_nxt = cand_hi;
      end
    end
  end

  // lower four code bits
  always_comb begin
    lo_nxt  = hi_r;
    cand_lo = '0;
    for (int i = 3; i >= 0; i--) begin
      cand_lo = lo_nxt | (8'd1 << i);
      if (lin_r >= ROOT_TH[cand_lo]) begin
        lo_nxt = cand_lo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_hi) begin
      hi_r  <= hi_nxt;
      lin_r <= lin_in;
    end
    if (ctl.adv_lo) begin
      lo_r <= lo_nxt;
    end
  end

  assign code_out = lo_r;

endmodule
`default_nettype wire
